// ----- src/twtlb_pkg.sv -----
`default_nettype none

package twtlb_pkg;

    localparam int unsigned DEF_SETS    = 64;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned TAG_W       = ADDR_W - PAGE_SHIFT;
    localparam int unsigned CHANGED_BIT = 7;

    localparam logic [ADDR_W-1:0] OFFSET_MASK = 32'h0000_0fff;
    localparam logic [ADDR_W-1:0] PAGE_MASK   = ~OFFSET_MASK;

    // action codes
    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_FILL   = 2'd1;
    localparam logic [1:0] ACT_INVAL  = 2'd2;

    // access kinds
    localparam logic [1:0] KIND_NOEXC  = 2'd0;
    localparam logic [1:0] KIND_READ   = 2'd1;
    localparam logic [1:0] KIND_WRITE  = 2'd2;
    localparam logic [1:0] KIND_IFETCH = 2'd3;

    // result status
    localparam logic [1:0] ST_HIT  = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_CHG  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_MOD,
        S_READ,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic vld;
        logic [TAG_W-1:0] tag;
        logic [ADDR_W-1:0] word;
    } t_way;

    typedef struct packed {
        logic recent;
        t_way [1:0] way;
    } t_row;

    typedef struct packed {
        logic clr_wr;    // clearing pass write
        logic load;      // capture request
        logic mul;       // reciprocal product
        logic mod;       // set index
        logic rd;        // row read
        logic exec;      // row update
        logic next_tbl;  // invalidate moves to instruction table
        logic out_load;  // load result register
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic inv;
        logic tbl;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// ----- src/twtlb_if.sv -----
`default_nettype none

interface twtlb_req_if;
    import twtlb_pkg::*;

    logic valid;
    logic ready;
    logic [1:0] action;
    logic [1:0] access_kind;
    logic [ADDR_W-1:0] virt_address;
    logic [ADDR_W-1:0] page_entry_word;

    modport source (output valid, action, access_kind, virt_address, page_entry_word,
                    input ready);
    modport sink (input valid, action, access_kind, virt_address, page_entry_word,
                  output ready);
endinterface

interface twtlb_rsp_if;
    import twtlb_pkg::*;

    logic valid;
    logic ready;
    logic [1:0] status;
    logic [ADDR_W-1:0] phys_address;

    modport source (output valid, status, phys_address, input ready);
    modport sink (input valid, status, phys_address, output ready);
endinterface

`default_nettype wire

// ----- src/twtlb_ctrl.sv -----
`default_nettype none

module twtlb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  twtlb_pkg::t_sts    i_sts,
    output twtlb_pkg::t_cmd    o_cmd
);
    import twtlb_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.mul = 1'b1;
                n_state   = S_MOD;
            end
            S_MOD: begin
                o_cmd.mod = 1'b1;
                n_state   = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                // invalidate: data table row first, then instruction table row
                if (i_sts.inv && !i_sts.tbl) begin
                    o_cmd.exec     = 1'b1;
                    o_cmd.next_tbl = 1'b1;
                    n_state        = S_READ;
                end else if (!i_sts.out_busy) begin
                    o_cmd.exec     = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/twtlb_dp.sv -----
`default_nettype none

module twtlb_dp #(
    parameter int unsigned SETS = twtlb_pkg::DEF_SETS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  twtlb_pkg::t_cmd                    i_cmd,
    output twtlb_pkg::t_sts                    o_sts,
    input  wire logic [1:0]                    i_action,
    input  wire logic [1:0]                    i_kind,
    input  wire logic [twtlb_pkg::ADDR_W-1:0]  i_va,
    input  wire logic [twtlb_pkg::ADDR_W-1:0]  i_pte,
    twtlb_rsp_if.source                        o_rsp
);
    import twtlb_pkg::*;

    localparam int unsigned ROWS  = 2 * SETS;
    localparam int unsigned ROW_W = $clog2(ROWS);
    localparam int unsigned SET_W = (SETS > 1) ? $clog2(SETS) : 1;
    // floor(2^32 / SETS); estimate of tag / SETS is low by at most one
    localparam logic [32:0] RECIP  = 33'((64'd1 << 32) / SETS);
    localparam int unsigned PROD_W = TAG_W + 33;

    logic [1:0]        r_action;
    logic [1:0]        r_kind;
    logic [ADDR_W-1:0] r_va;
    logic [ADDR_W-1:0] r_pte;
    logic              r_tbl;
    logic [PROD_W-1:0] r_prod;
    logic [SET_W-1:0]  r_set;
    logic [ROW_W-1:0]  r_clr_cnt;
    t_row              r_rd;
    logic              r_out_vld;
    logic [1:0]        r_status;
    logic [ADDR_W-1:0] r_phys;

    t_row r_mem [ROWS];

    logic [TAG_W-1:0]  w_tag;
    logic [TAG_W-1:0]  w_q;
    logic [31:0]       w_qs;
    logic [TAG_W-1:0]  w_rem;
    logic [TAG_W-1:0]  w_rem_c;
    logic [ROW_W-1:0]  w_row_addr;
    logic [ROW_W-1:0]  w_addr;
    logic              w_hit0;
    logic              w_hit1;
    logic              w_hway;
    logic [ADDR_W-1:0] w_hword;
    logic              w_fway;
    t_row              w_row;
    logic              w_row_we;
    logic              w_we;
    t_row              w_wd;
    logic [1:0]        w_status;
    logic [ADDR_W-1:0] w_phys;

    assign w_tag = r_va[ADDR_W-1:PAGE_SHIFT];

    // set = tag mod SETS by reciprocal multiply and one correction
    assign w_q     = r_prod[PROD_W-2:32];
    assign w_qs    = 32'(w_q) * 32'(SETS);
    assign w_rem   = w_tag - w_qs[TAG_W-1:0];
    assign w_rem_c = (32'(w_rem) >= 32'(SETS)) ? w_rem - TAG_W'(SETS) : w_rem;

    assign w_row_addr = r_tbl ? ROW_W'(SETS) + ROW_W'(r_set) : ROW_W'(r_set);
    assign w_addr     = i_cmd.clr_wr ? r_clr_cnt : w_row_addr;

    assign w_hit0  = r_rd.way[0].vld && (r_rd.way[0].tag == w_tag);
    assign w_hit1  = r_rd.way[1].vld && (r_rd.way[1].tag == w_tag);
    assign w_hway  = !w_hit0;
    assign w_hword = r_rd.way[w_hway].word;
    assign w_fway  = !r_rd.recent && r_rd.way[0].vld;

    always_comb begin
        w_row    = r_rd;
        w_row_we = 1'b0;
        w_status = ST_HIT;
        w_phys   = '0;
        unique case (r_action)
            ACT_LOOKUP: begin
                if (w_hit0 || w_hit1) begin
                    if (r_kind == KIND_WRITE && !w_hword[CHANGED_BIT]) begin
                        w_row.way[w_hway].word[CHANGED_BIT] = 1'b1;
                        w_row_we = 1'b1;
                        w_status = ST_CHG;
                    end else begin
                        if (r_kind != KIND_NOEXC) begin
                            w_row.recent = w_hway;
                            w_row_we     = 1'b1;
                        end
                        w_phys = (w_hword & PAGE_MASK) | (r_va & OFFSET_MASK);
                    end
                end else begin
                    w_status = ST_MISS;
                end
            end
            ACT_FILL: begin
                if (r_kind != KIND_NOEXC) begin
                    w_row.way[w_fway].vld  = 1'b1;
                    w_row.way[w_fway].tag  = w_tag;
                    w_row.way[w_fway].word = r_pte;
                    w_row.recent           = w_fway;
                    w_row_we               = 1'b1;
                end
            end
            ACT_INVAL: begin
                w_row.way[0].vld = 1'b0;
                w_row.way[1].vld = 1'b0;
                w_row_we         = 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign w_we = i_cmd.clr_wr || (i_cmd.exec && w_row_we);
    assign w_wd = i_cmd.clr_wr ? t_row'('0) : w_row;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_addr] <= w_wd;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_kind   <= i_kind;
            r_va     <= i_va;
            r_pte    <= i_pte;
            r_tbl    <= (i_action != ACT_INVAL) && (i_kind == KIND_IFETCH);
        end else if (i_cmd.next_tbl) begin
            r_tbl <= 1'b1;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(w_tag) * PROD_W'(RECIP);
        end
        if (i_cmd.mod) begin
            r_set <= w_rem_c[SET_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_status <= w_status;
            r_phys   <= w_phys;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last = (r_clr_cnt == ROW_W'(ROWS - 1));
    assign o_sts.inv      = (r_action == ACT_INVAL);
    assign o_sts.tbl      = r_tbl;
    assign o_sts.out_busy = r_out_vld && !o_rsp.ready;

    assign o_rsp.valid        = r_out_vld;
    assign o_rsp.status       = r_status;
    assign o_rsp.phys_address = r_phys;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !(r_out_vld && !o_rsp.ready))
        else $error("result register overwritten before transaction");

    a_set_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.mod) |-> (32'(r_set) < 32'(SETS)))
        else $error("set index out of range");

    a_clr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clr_wr |-> !(i_cmd.exec || i_cmd.rd || i_cmd.load))
        else $error("clearing pass overlaps an operation");

endmodule

`default_nettype wire

// ----- src/two_way_tlb_with_changed_bit.sv -----
`default_nettype none

// channel   dir  modport  payload
// i_req     in   sink     action, access_kind, virt_address, page_entry_word
// o_rsp     out  source   status, phys_address
//
// Each transaction runs from acceptance to result through set hash multiply, remainder,
// row read and update; an invalidate does the row read and update once per table.
// The shared row memory has one port, so one request is in flight at a time.
// After reset a clearing pass writes all 2*SETS rows; i_req.ready stays low meanwhile.
// A stalled o_rsp holds the result; the next request is still accepted and waits
// in the update step until the result register frees.
module two_way_tlb_with_changed_bit #(
    parameter int unsigned SETS = twtlb_pkg::DEF_SETS
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    twtlb_req_if.sink   i_req,
    twtlb_rsp_if.source o_rsp
);
    import twtlb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_req.ready = w_in_ready;

    twtlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    twtlb_dp #(
        .SETS (SETS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_action (i_req.action),
        .i_kind   (i_req.access_kind),
        .i_va     (i_req.virt_address),
        .i_pte    (i_req.page_entry_word),
        .o_rsp    (o_rsp)
    );

endmodule

`default_nettype wire
